### rtl/alt_pkg.sv
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants for the address learning table
// Transaction structs, entry layout and controller states.
// ----------------------------------------------------------------------------
package alt_pkg;

	localparam int ADDR_W = 48;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 5;

	// request transaction kinds
	localparam logic KIND_OBSERVE = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] address;
		logic [TIME_W-1:0] now_ms;
		logic [SLOT_W-1:0] read_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              inserted;
		logic              full_res;
		logic              entry_valid;
		logic [ADDR_W-1:0] entry_address;
		logic [TIME_W-1:0] entry_seen;
	} rsp_t;

	// one stored table entry
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [TIME_W-1:0] seen;
	} ent_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RDWAIT,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

### rtl/alt_ram.sv
// ----------------------------------------------------------------------------
// alt_ram: entry storage
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module alt_ram
	import alt_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  ent_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output ent_t          rdata
);

	ent_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/address_learning_table.sv
// ----------------------------------------------------------------------------
// address_learning_table: learned source address table
// Observe transactions look up an address and refresh or insert it; read
// transactions return one slot. Entries fill from slot 0 upward.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------
//   req     | in        | req_valid/req_stall | req_t (kind, address, ...)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_t (slot, hit, ...)
//
// Read transaction: a slot at or above the fill point goes straight to the result
// register; a filled slot is read from the entry RAM first.
// Observe transaction: a hit stops the scan at its slot, a miss inserts at the
// fill point or, on a full table, drops the address; the scan reads one
// entry per cycle through the single read port of the entry RAM.
// One transaction in flight; the next is accepted once the result is parked.
// Reset clears the fill count and control state; the entry RAM needs no clearing pass.
// A stalled result stays in the output register while a new request runs.
//
module address_learning_table
	import alt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW   = $clog2(TABLE_ENTRIES + 1);
	localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

	state_t        state_q, state_d;
	req_t          item_q;
	rsp_t          res_q, res_d;
	rsp_t          rsp_q;
	logic          rsp_valid_q;
	logic [CW-1:0] cnt_q;
	logic          cnt_inc;
	logic [CW-1:0] scan_idx_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          issuing;
	logic          match;
	logic          rd_in_table;
	logic          accept;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	ent_t          ram_wdata, ram_rdata;

	alt_ram #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// valid entries are exactly slots below the fill count
	assign rd_in_table = CMPW'(req.read_slot) < CMPW'(cnt_q);
	assign issuing     = (state_q == S_SCAN) && (scan_idx_q < cnt_q);
	assign match       = cmp_vld_s1 && (ram_rdata.addr == item_q.address);
	assign ram_wdata   = '{addr: item_q.address, seen: item_q.now_ms};

	// controller
	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		ram_re    = 1'b0;
		ram_raddr = scan_idx_q[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = cmp_idx_s1;
		cnt_inc   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.kind == KIND_READ) begin
						res_d      = '0;
						res_d.slot = req.read_slot;
						if (rd_in_table) begin
							ram_re    = 1'b1;
							ram_raddr = IW'(req.read_slot);
							state_d   = S_RDWAIT;
						end else begin
							state_d = S_DONE;
						end
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_RDWAIT: begin
				res_d.entry_valid   = 1'b1;
				res_d.entry_address = ram_rdata.addr;
				res_d.entry_seen    = ram_rdata.seen;
				state_d             = S_DONE;
			end
			S_SCAN: begin
				ram_re = issuing;
				if (match) begin
					// refresh time of the matching entry
					ram_we     = 1'b1;
					ram_waddr  = cmp_idx_s1;
					res_d      = '0;
					res_d.slot = SLOT_W'(cmp_idx_s1);
					res_d.hit  = 1'b1;
					state_d    = S_DONE;
				end else if (!issuing && !cmp_vld_s1) begin
					// scan exhausted: insert at fill point or drop
					res_d = '0;
					if (cnt_q < CW'(TABLE_ENTRIES)) begin
						ram_we         = 1'b1;
						ram_waddr      = cnt_q[IW-1:0];
						cnt_inc        = 1'b1;
						res_d.slot     = SLOT_W'(cnt_q);
						res_d.inserted = 1'b1;
					end else begin
						res_d.full_res = 1'b1;
					end
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			scan_idx_q  <= '0;
			cmp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issuing;
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				scan_idx_q <= '0;
			end else if (issuing) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q      <= res_d;
		cmp_idx_s1 <= scan_idx_q[IW-1:0];
		if (accept) begin
			item_q <= req;
		end
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= res_q;
		end
	end

endmodule

### rtl/alt_checker.sv
// ----------------------------------------------------------------------------
// alt_checker: port-level checks for the address learning table
// Watches both channels and the result encoding.
// ----------------------------------------------------------------------------
module alt_checker
	import alt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// one transaction in flight: input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	// stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// at most one observe outcome
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.hit, rsp.inserted, rsp.full_res}))
		else $error("more than one observe outcome");

	// a valid read carries no observe flags
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.entry_valid |-> !rsp.hit && !rsp.inserted && !rsp.full_res)
		else $error("read result carries observe flags");

	// dropped address reports slot zero and empty entry fields
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.full_res |->
			rsp.slot == '0 && rsp.entry_address == '0 && rsp.entry_seen == '0)
		else $error("full result has nonzero fields");

endmodule

bind address_learning_table alt_checker u_alt_checker (.*);

### verif/tb_address_learning_table.sv
// ----------------------------------------------------------------------------
// tb_address_learning_table: self-checking bench for the address table
// Drives observe and read transactions through the valid/stall request
// channel and checks every result against a scoreboard. The scoreboard keeps
// its own copy of the learned table. Directed corner cases run first. Random
// traffic follows: mostly repeat sightings, some new and near-miss addresses,
// and reads of learned and empty slots. The table fills up during the run, so
// the full-table drop path is exercised as well.
// ----------------------------------------------------------------------------
module tb_address_learning_table
	import alt_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 32;
	localparam int RANDOM_ITEMS = 830;
	localparam int FILL_FORCE   = 450;  // after this many items, force the table to fill
	localparam int HOLD_AFTER   = 300;  // start the long result hold-off here
	localparam int LONG_HOLD    = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_MAX   = 10;

	// Scoreboard: shadow copy of the table plus the queue of pending results
	class learn_table_scoreboard;
		bit              active [TABLE_DEPTH];
		bit [ADDR_W-1:0] stored_addr [TABLE_DEPTH];
		bit [TIME_W-1:0] stored_seen [TABLE_DEPTH];
		rsp_t            expected_q [$];
		int unsigned     errors;

		function void flag(string what, logic [63:0] exp_v, logic [63:0] got_v);
			errors++;
			if (errors <= REPORT_MAX)
				$display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h",
					$time, what, exp_v, got_v);
		endfunction

		// Predict the result of one accepted request and update the shadow table
		function void note_request(req_t r);
			rsp_t e;
			int   hit_idx;
			int   free_idx;
			e = '0;
			hit_idx = -1;
			free_idx = -1;
			if (r.kind == KIND_READ) begin
				e.slot = r.read_slot;
				if (r.read_slot < TABLE_DEPTH && active[r.read_slot]) begin
					e.entry_valid   = 1'b1;
					e.entry_address = stored_addr[r.read_slot];
					e.entry_seen    = stored_seen[r.read_slot];
				end
			end else begin
				for (int k = 0; k < TABLE_DEPTH; k++) begin
					if (hit_idx < 0 && active[k] && stored_addr[k] == r.address)
						hit_idx = k;
					if (free_idx < 0 && !active[k])
						free_idx = k;
				end
				if (hit_idx >= 0) begin
					stored_seen[hit_idx] = r.now_ms;
					e.slot = SLOT_W'(hit_idx);
					e.hit  = 1'b1;
				end else if (free_idx >= 0) begin
					active[free_idx]      = 1'b1;
					stored_addr[free_idx] = r.address;
					stored_seen[free_idx] = r.now_ms;
					e.slot     = SLOT_W'(free_idx);
					e.inserted = 1'b1;
				end else begin
					e.full_res = 1'b1;
				end
			end
			expected_q.push_back(e);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				flag("result with no pending transaction", 64'd0, 64'(got));
				return;
			end
			e = expected_q.pop_front();
			if (got.slot !== e.slot)
				flag("slot", 64'(e.slot), 64'(got.slot));
			if (got.hit !== e.hit)
				flag("hit", 64'(e.hit), 64'(got.hit));
			if (got.inserted !== e.inserted)
				flag("inserted", 64'(e.inserted), 64'(got.inserted));
			if (got.full_res !== e.full_res)
				flag("full_res", 64'(e.full_res), 64'(got.full_res));
			if (got.entry_valid !== e.entry_valid)
				flag("entry_valid", 64'(e.entry_valid), 64'(got.entry_valid));
			if (got.entry_address !== e.entry_address)
				flag("entry_address", 64'(e.entry_address), 64'(got.entry_address));
			if (got.entry_seen !== e.entry_seen)
				flag("entry_seen", 64'(e.entry_seen), 64'(got.entry_seen));
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		function int unsigned total_failures();
			if (expected_q.size() != 0)
				flag("results never delivered", 64'd0, 64'(expected_q.size()));
			return errors;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	learn_table_scoreboard table_sb = new();

	// stimulus-side view of the table: addresses that will be learned, in slot order
	bit [ADDR_W-1:0] learned_addrs [$];
	int unsigned     sent_count = 0;
	int unsigned     burst_left = 0;

	address_learning_table #(
		.TABLE_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Transaction monitors on both channels
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			table_sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			table_sb.check_response(rsp);
	end

	function automatic bit is_learned(bit [ADDR_W-1:0] a);
		foreach (learned_addrs[i])
			if (learned_addrs[i] == a)
				return 1'b1;
		return 1'b0;
	endfunction

	// Address not in the table: fully random or one bit away from a learned one
	function automatic bit [ADDR_W-1:0] fresh_address();
		bit [ADDR_W-1:0] a;
		do begin
			a = {16'($urandom), 32'($urandom)};
			if (learned_addrs.size() != 0 && $urandom_range(0, 2) == 0)
				a = learned_addrs[$urandom_range(0, learned_addrs.size() - 1)]
					^ (48'd1 << $urandom_range(0, ADDR_W - 1));
		end while (is_learned(a));
		return a;
	endfunction

	function automatic bit [TIME_W-1:0] pick_time();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Offer one transaction, wait for acceptance, then maybe end the burst
	task automatic send_request(input req_t item);
		int unsigned gap;
		if (item.kind == KIND_OBSERVE && !is_learned(item.address)
				&& learned_addrs.size() < TABLE_DEPTH)
			learned_addrs.push_back(item.address);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_observe(input bit [ADDR_W-1:0] a, input bit [TIME_W-1:0] t);
		req_t item;
		item.kind      = KIND_OBSERVE;
		item.address   = a;
		item.now_ms    = t;
		item.read_slot = SLOT_W'($urandom);
		send_request(item);
	endtask

	// empty slots read back as an invalid entry
	task automatic send_read(input bit [SLOT_W-1:0] s);
		req_t item;
		item.kind      = KIND_READ;
		item.address   = {16'($urandom), 32'($urandom)};
		item.now_ms    = $urandom;
		item.read_slot = s;
		send_request(item);
	endtask

	// Result side stall pattern, with one long hold-off to back up the block
	initial begin : rsp_pacing
		int unsigned mode;
		int unsigned run_len;
		bit          long_done;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_done && sent_count >= HOLD_AFTER) begin
				long_done = 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					rsp_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(1, 40);
			repeat (run_len) begin
				@(posedge clk);
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 1) == 0);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Watchdog: end the run if no transaction moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int unsigned roll;
		int unsigned new_pct;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, refresh of existing entries, neighbors
		send_read(5'd31);
		send_read(5'd0);
		send_observe('0, '0);
		send_observe('1, '1);
		send_observe('0, '1);
		send_read(5'd0);
		send_read(5'd1);
		send_observe('1, '0);
		send_read(5'd1);
		send_observe(48'h0000_0000_0001, 32'h8000_0000);
		send_observe(48'h8000_0000_0000, 32'h0000_0001);
		send_observe(48'hFFFF_FFFF_FFFE, 32'h7FFF_FFFF);
		send_observe(48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFE);
		send_observe(48'hAAAA_AAAA_AAAA, 32'h5555_5555);
		send_observe(48'h5555_5555_5555, 32'hAAAA_AAAA);
		send_read(5'd2);
		send_read(5'd3);
		send_read(5'd4);
		send_read(5'd5);
		send_read(5'd6);
		send_read(5'd7);
		send_read(5'd8);
		send_observe(48'h8000_0000_0000, 32'h1234_5678);
		send_read(5'd3);
		send_observe(48'h0000_0000_0001, '0);
		send_read(5'd2);

		// random: mostly repeat sightings, some new addresses, some reads
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			new_pct = (n > FILL_FORCE && learned_addrs.size() < TABLE_DEPTH) ? 100 : 10;
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_read(SLOT_W'($urandom));
			else if (roll < 20)
				send_read(SLOT_W'($urandom_range(0, learned_addrs.size() - 1)));
			else if (roll < 20 + new_pct)
				send_observe(fresh_address(), pick_time());
			else
				send_observe(learned_addrs[$urandom_range(0, learned_addrs.size() - 1)],
					pick_time());
		end
		req_valid <= 1'b0;

		while (table_sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (table_sb.total_failures() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
